// File: design/mnd_pkg.sv
`timescale 1ns / 1ps

package mnd_pkg;

  // Fixed-point format and image bounds
  localparam int FRAC_BITS   = 24;
  localparam int MAX_COLUMNS = 4096;
  localparam int MAX_ROWS    = 4096;

  // Field widths
  localparam int COORD_W    = 12;
  localparam int CNT_W      = 12;
  localparam int ORG_W      = 28;
  localparam int STEP_W     = 26;
  localparam int C_W        = 32;
  localparam int Z_W        = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 28;

  // Iteration datapath: 40x40 products built from 21x21 partial products
  localparam int PART_W    = Z_W / 2;
  localparam int PP_W      = 2 * (PART_W + 1);
  localparam int ACC_W     = 2 * Z_W;
  localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;

  // Reset values of the configuration registers
  localparam logic signed [ORG_W-1:0]  X_ORIGIN_RST = ORG_W'(-33554432);
  localparam logic signed [STEP_W-1:0] X_STEP_RST   = STEP_W'(49152);
  localparam logic signed [ORG_W-1:0]  Y_ORIGIN_RST = ORG_W'(-25165824);
  localparam logic signed [STEP_W-1:0] Y_STEP_RST   = STEP_W'(49152);
  localparam logic [CNT_W-1:0]         LIMIT_RST    = CNT_W'(1000);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_X_ORIGIN   = 3'd0,
    CFG_X_STEP     = 3'd1,
    CFG_Y_ORIGIN   = 3'd2,
    CFG_Y_STEP     = 3'd3,
    CFG_ITER_LIMIT = 3'd4
  } cfg_reg_t;

  // Point c handed from the front end to the iteration engine
  typedef struct packed {
    logic signed [C_W-1:0] re;
    logic signed [C_W-1:0] im;
  } c_point_t;

  // Point queue status
  typedef struct packed {
    logic full;
    logic empty;
  } fq_stat_t;

endpackage

// File: design/mnd_pix_if.sv
`timescale 1ns / 1ps

interface mnd_pix_if;
  logic                       valid;
  logic                       ready;
  logic [mnd_pkg::COORD_W-1:0] column;
  logic [mnd_pkg::COORD_W-1:0] row;

  modport source (output valid, column, row, input ready);
  modport sink   (input valid, column, row, output ready);
endinterface

// File: design/mnd_res_if.sv
`timescale 1ns / 1ps

interface mnd_res_if;
  logic                     valid;
  logic                     ready;
  logic [mnd_pkg::CNT_W-1:0] iteration_count;
  logic                     inside_set;

  modport source (output valid, iteration_count, inside_set, input ready);
  modport sink   (input valid, iteration_count, inside_set, output ready);
endinterface

// File: design/mnd_cfg_if.sv
`timescale 1ns / 1ps

interface mnd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mnd_pkg::CFG_IDX_W-1:0]  index;
  logic [mnd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/mnd_fifo.sv
`timescale 1ns / 1ps

// Small point queue between front end and iteration engine (DEPTH >= 2)
module mnd_fifo #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  mnd_pkg::c_point_t wr_data,
  input  logic              pop,
  output mnd_pkg::c_point_t rd_data,
  output mnd_pkg::fq_stat_t stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  mnd_pkg::c_point_t mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  // Pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data    = mem_r[rd_ptr_r];
  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);

endmodule

// File: design/mnd_front.sv
`timescale 1ns / 1ps

// Pixel to point c: clamp, scale (stage A), add origin and saturate (stage B)
module mnd_front (
  input  logic                                clk,
  input  logic                                rst_n,
  mnd_pix_if.sink                             in_pix,
  input  logic signed [mnd_pkg::ORG_W-1:0]    x_origin,
  input  logic signed [mnd_pkg::STEP_W-1:0]   x_step,
  input  logic signed [mnd_pkg::ORG_W-1:0]    y_origin,
  input  logic signed [mnd_pkg::STEP_W-1:0]   y_step,
  output logic                                push,
  output mnd_pkg::c_point_t                   push_data,
  input  mnd_pkg::fq_stat_t                   stat
);

  localparam int PROD_W = mnd_pkg::COORD_W + 1 + mnd_pkg::STEP_W;
  localparam int SUM_W  = PROD_W + 1;

  function automatic logic signed [mnd_pkg::C_W-1:0] sat_c(logic signed [SUM_W-1:0] v);
    logic [SUM_W-mnd_pkg::C_W:0] top;
    top = v[SUM_W-1:mnd_pkg::C_W-1];
    if ((&top) || !(|top)) begin
      return v[mnd_pkg::C_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(mnd_pkg::C_W-1){1'b0}}};
    end else begin
      return {1'b0, {(mnd_pkg::C_W-1){1'b1}}};
    end
  endfunction

  logic [mnd_pkg::COORD_W-1:0] col_cl, row_cl;
  logic signed [PROD_W-1:0]    prod_re, prod_im;
  logic signed [PROD_W-1:0]    prod_re_r, prod_im_r;
  logic                        a_valid_r, a_valid_nxt;
  logic                        accept;
  logic signed [SUM_W-1:0]     sum_re, sum_im;

  // Clamp indexes to the image
  always_comb begin
    col_cl = (int'(in_pix.column) > mnd_pkg::MAX_COLUMNS - 1) ?
             mnd_pkg::COORD_W'(mnd_pkg::MAX_COLUMNS - 1) : in_pix.column;
    row_cl = (int'(in_pix.row) > mnd_pkg::MAX_ROWS - 1) ?
             mnd_pkg::COORD_W'(mnd_pkg::MAX_ROWS - 1) : in_pix.row;
  end

  assign prod_re = $signed({1'b0, col_cl}) * x_step;
  assign prod_im = $signed({1'b0, row_cl}) * y_step;

  // Stage A handshake: holds while the queue is full
  assign push         = a_valid_r && !stat.full;
  assign in_pix.ready = !a_valid_r || push;
  assign accept       = in_pix.valid && in_pix.ready;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept) begin
      a_valid_nxt = 1'b1;
    end else if (push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_re_r <= prod_re;
      prod_im_r <= prod_im;
    end
  end

  // Stage B: origin add and saturate into the queue word
  assign sum_re = $signed({prod_re_r[PROD_W-1], prod_re_r}) +
                  $signed({{(SUM_W-mnd_pkg::ORG_W){x_origin[mnd_pkg::ORG_W-1]}}, x_origin});
  assign sum_im = $signed({prod_im_r[PROD_W-1], prod_im_r}) +
                  $signed({{(SUM_W-mnd_pkg::ORG_W){y_origin[mnd_pkg::ORG_W-1]}}, y_origin});

  assign push_data.re = sat_c(sum_re);
  assign push_data.im = sat_c(sum_im);

endmodule

// File: design/mnd_iter.sv
`timescale 1ns / 1ps

// Escape-time engine: z = z*z + c with three 21x21 multiply lanes
module mnd_iter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mnd_pkg::c_point_t           pt,
  input  mnd_pkg::fq_stat_t           stat,
  output logic                        pop,
  input  logic [mnd_pkg::CNT_W-1:0]   limit,
  mnd_res_if.source                   out_res
);

  localparam int Z_W    = mnd_pkg::Z_W;
  localparam int C_W    = mnd_pkg::C_W;
  localparam int PART_W = mnd_pkg::PART_W;
  localparam int PP_W   = mnd_pkg::PP_W;
  localparam int ACC_W  = mnd_pkg::ACC_W;
  localparam int CNT_W  = mnd_pkg::CNT_W;
  localparam int LANES  = 3;
  localparam logic [ACC_W:0] ESC_LIM = (ACC_W + 1)'(1) << mnd_pkg::ESC_SHIFT;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_EVAL = 6'b001000,
    S_ADD  = 6'b010000,
    S_DONE = 6'b100000
  } iter_state_t;

  // Low half unsigned or high half signed, as a 21-bit signed operand
  function automatic logic signed [PART_W:0] half_sel(logic signed [Z_W-1:0] v, logic hi);
    if (hi) begin
      return {v[Z_W-1], v[Z_W-1:PART_W]};
    end else begin
      return {1'b0, v[PART_W-1:0]};
    end
  endfunction

  // Saturate a shifted product term to the z range
  function automatic logic signed [Z_W-1:0] sat_prod(logic signed [ACC_W:0] v);
    logic [ACC_W-Z_W+1:0] top;
    top = v[ACC_W:Z_W-1];
    if ((&top) || !(|top)) begin
      return v[Z_W-1:0];
    end else if (v[ACC_W]) begin
      return {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Z_W-1){1'b1}}};
    end
  endfunction

  // Saturate z + c to the z range
  function automatic logic signed [Z_W-1:0] sat_add(logic signed [Z_W:0] v);
    if (v[Z_W] == v[Z_W-1]) begin
      return v[Z_W-1:0];
    end else if (v[Z_W]) begin
      return {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Z_W-1){1'b1}}};
    end
  endfunction

  iter_state_t             state_r, state_nxt;
  logic signed [Z_W-1:0]   zr_r, zr_nxt, zi_r, zi_nxt;
  logic signed [C_W-1:0]   cr_r, cr_nxt, ci_r, ci_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt, n_inc;
  logic                    chk_r, chk_nxt;
  logic [1:0]              k_r, k_nxt;
  logic signed [ACC_W-1:0] acc_r [LANES];
  logic signed [ACC_W-1:0] acc_nxt [LANES];
  logic signed [ACC_W-1:0] acc_add [LANES];
  logic signed [PP_W-1:0]  pp_r [LANES];
  logic signed [PP_W-1:0]  pp_nxt [LANES];
  logic [1:0]              pp_k_r;
  logic                    pp_v_r, pp_v_nxt;
  logic                    acc_clr;
  logic signed [Z_W-1:0]   lane_a [LANES];
  logic signed [Z_W-1:0]   lane_b [LANES];
  logic signed [PART_W:0]  op_a [LANES];
  logic signed [PART_W:0]  op_b [LANES];
  logic signed [Z_W-1:0]   tre_r, tre_nxt, tim_r, tim_nxt;
  logic [CNT_W-1:0]        cnt_out_r, cnt_out_nxt;
  logic                    inside_r, inside_nxt;
  logic [ACC_W:0]          sq_sum;
  logic signed [ACC_W:0]   diff, re_sh, dbl, im_sh;
  logic signed [Z_W:0]     zr_sum, zi_sum;
  logic                    escape;

  // Lane operands: z_re^2, z_im^2, z_re*z_im
  always_comb begin
    lane_a[0] = zr_r;
    lane_b[0] = zr_r;
    lane_a[1] = zi_r;
    lane_b[1] = zi_r;
    lane_a[2] = zr_r;
    lane_b[2] = zi_r;
    for (int l = 0; l < LANES; l++) begin
      op_a[l]   = half_sel(lane_a[l], k_r[1]);
      op_b[l]   = half_sel(lane_b[l], k_r[0]);
      pp_nxt[l] = op_a[l] * op_b[l];
    end
  end

  // Align the registered partial product by its weight
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      unique case (pp_k_r)
        2'd0:    acc_add[l] = ACC_W'(pp_r[l]);
        2'd3:    acc_add[l] = ACC_W'(pp_r[l]) <<< (2 * PART_W);
        default: acc_add[l] = ACC_W'(pp_r[l]) <<< PART_W;
      endcase
      if (acc_clr) begin
        acc_nxt[l] = '0;
      end else if (pp_v_r) begin
        acc_nxt[l] = acc_r[l] + acc_add[l];
      end else begin
        acc_nxt[l] = acc_r[l];
      end
    end
  end

  // Escape test and new z terms from the finished products
  assign sq_sum = {acc_r[0][ACC_W-1], acc_r[0]} + {acc_r[1][ACC_W-1], acc_r[1]};
  assign escape = chk_r && (sq_sum > ESC_LIM);
  assign diff   = $signed({acc_r[0][ACC_W-1], acc_r[0]}) -
                  $signed({acc_r[1][ACC_W-1], acc_r[1]});
  assign re_sh  = diff >>> mnd_pkg::FRAC_BITS;
  assign dbl    = $signed({acc_r[2], 1'b0});
  assign im_sh  = dbl >>> mnd_pkg::FRAC_BITS;
  assign zr_sum = $signed({tre_r[Z_W-1], tre_r}) +
                  $signed({{(Z_W+1-C_W){cr_r[C_W-1]}}, cr_r});
  assign zi_sum = $signed({tim_r[Z_W-1], tim_r}) +
                  $signed({{(Z_W+1-C_W){ci_r[C_W-1]}}, ci_r});
  assign n_inc  = n_r + 1'b1;

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    zr_nxt      = zr_r;
    zi_nxt      = zi_r;
    cr_nxt      = cr_r;
    ci_nxt      = ci_r;
    n_nxt       = n_r;
    chk_nxt     = chk_r;
    k_nxt       = k_r;
    tre_nxt     = tre_r;
    tim_nxt     = tim_r;
    cnt_out_nxt = cnt_out_r;
    inside_nxt  = inside_r;
    acc_clr     = 1'b0;
    pop         = 1'b0;
    pp_v_nxt    = (state_r == S_MUL);
    unique case (state_r)
      S_IDLE: begin
        if (!stat.empty) begin
          pop     = 1'b1;
          zr_nxt  = {{(Z_W-C_W){pt.re[C_W-1]}}, pt.re};
          zi_nxt  = {{(Z_W-C_W){pt.im[C_W-1]}}, pt.im};
          cr_nxt  = pt.re;
          ci_nxt  = pt.im;
          n_nxt   = '0;
          chk_nxt = 1'b0;
          k_nxt   = '0;
          acc_clr = 1'b1;
          if (limit == '0) begin
            cnt_out_nxt = '0;
            inside_nxt  = 1'b1;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        k_nxt = k_r + 1'b1;
        if (k_r == 2'd3) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (escape) begin
          cnt_out_nxt = n_r;
          inside_nxt  = (n_r == limit);
          state_nxt   = S_DONE;
        end else if (chk_r && (n_inc == limit)) begin
          cnt_out_nxt = n_inc;
          inside_nxt  = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          if (chk_r) begin
            n_nxt = n_inc;
          end
          tre_nxt   = sat_prod(re_sh);
          tim_nxt   = sat_prod(im_sh);
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        zr_nxt    = sat_add(zr_sum);
        zi_nxt    = sat_add(zi_sum);
        chk_nxt   = 1'b1;
        k_nxt     = '0;
        acc_clr   = 1'b1;
        state_nxt = S_MUL;
      end
      S_DONE: begin
        if (out_res.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pp_v_r  <= 1'b0;
      k_r     <= '0;
      chk_r   <= 1'b0;
      n_r     <= '0;
    end else begin
      state_r <= state_nxt;
      pp_v_r  <= pp_v_nxt;
      k_r     <= k_nxt;
      chk_r   <= chk_nxt;
      n_r     <= n_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    zr_r      <= zr_nxt;
    zi_r      <= zi_nxt;
    cr_r      <= cr_nxt;
    ci_r      <= ci_nxt;
    tre_r     <= tre_nxt;
    tim_r     <= tim_nxt;
    cnt_out_r <= cnt_out_nxt;
    inside_r  <= inside_nxt;
    pp_k_r    <= k_r;
    for (int l = 0; l < LANES; l++) begin
      pp_r[l]  <= pp_nxt[l];
      acc_r[l] <= acc_nxt[l];
    end
  end

  assign out_res.valid           = (state_r == S_DONE);
  assign out_res.iteration_count = cnt_out_r;
  assign out_res.inside_set      = inside_r;

endmodule

// File: design/mandelbrot_escape_time.sv
`timescale 1ns / 1ps

// Channel   Port      Word                         Handshake
// -------   -------   --------------------------   ------------------------
// pixel     in_pix    column, row                  valid/ready, sink
// result    out_res   iteration_count, inside_set  valid/ready, source
// config    cfg_wr    index, data                  valid/ready, always ready
//
// Front end takes a pixel every cycle while the point queue has room and
// pushes c into the queue from its stage A register. The iteration engine
// runs each z update as four partial-product steps on three 21x21
// multipliers, then an accumulate, an evaluate and an add state, and works
// on one point at a time. Reset (rst_n low, synchronous) loads the default
// view and a limit of 1000 and empties the queue. A waiting result holds
// the engine; pixels still enter until the queue and the front stage are
// full.
module mandelbrot_escape_time #(
  parameter int QUEUE_DEPTH = 2
) (
  input logic        clk,
  input logic        rst_n,
  mnd_pix_if.sink    in_pix,
  mnd_res_if.source  out_res,
  mnd_cfg_if.sink    cfg_wr
);

  logic signed [mnd_pkg::ORG_W-1:0]  x_origin_r, y_origin_r;
  logic signed [mnd_pkg::STEP_W-1:0] x_step_r, y_step_r;
  logic [mnd_pkg::CNT_W-1:0]         limit_r;

  mnd_pkg::c_point_t fq_wr_data, fq_rd_data;
  mnd_pkg::fq_stat_t fq_stat;
  logic              fq_push, fq_pop;

  // Configuration registers
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_origin_r <= mnd_pkg::X_ORIGIN_RST;
      x_step_r   <= mnd_pkg::X_STEP_RST;
      y_origin_r <= mnd_pkg::Y_ORIGIN_RST;
      y_step_r   <= mnd_pkg::Y_STEP_RST;
      limit_r    <= mnd_pkg::LIMIT_RST;
    end else if (cfg_wr.valid) begin
      unique case (mnd_pkg::cfg_reg_t'(cfg_wr.index))
        mnd_pkg::CFG_X_ORIGIN:   x_origin_r <= cfg_wr.data[mnd_pkg::ORG_W-1:0];
        mnd_pkg::CFG_X_STEP:     x_step_r   <= cfg_wr.data[mnd_pkg::STEP_W-1:0];
        mnd_pkg::CFG_Y_ORIGIN:   y_origin_r <= cfg_wr.data[mnd_pkg::ORG_W-1:0];
        mnd_pkg::CFG_Y_STEP:     y_step_r   <= cfg_wr.data[mnd_pkg::STEP_W-1:0];
        mnd_pkg::CFG_ITER_LIMIT: limit_r    <= cfg_wr.data[mnd_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mnd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .x_origin  (x_origin_r),
    .x_step    (x_step_r),
    .y_origin  (y_origin_r),
    .y_step    (y_step_r),
    .push      (fq_push),
    .push_data (fq_wr_data),
    .stat      (fq_stat)
  );

  mnd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fq_push),
    .wr_data (fq_wr_data),
    .pop     (fq_pop),
    .rd_data (fq_rd_data),
    .stat    (fq_stat)
  );

  mnd_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .pt      (fq_rd_data),
    .stat    (fq_stat),
    .pop     (fq_pop),
    .limit   (limit_r),
    .out_res (out_res)
  );

  // Queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fq_push |-> !fq_stat.full)
    else $error("point queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> !fq_stat.empty)
    else $error("point queue read while empty");

  // Engine takes a new point only once the previous result has left
  a_pop_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> !out_res.valid)
    else $error("new point taken while a result waits");

endmodule

// File: tb/sv/mandelbrot_escape_checker.sv
`timescale 1ns / 1ps

// Watches the pixel, result and config channels of the escape-time block,
// computes the expected word for every accepted pixel and checks result words
// in order against it.
module mandelbrot_escape_checker
  import mnd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  mnd_pix_if   pix,
  mnd_res_if   res,
  mnd_cfg_if   cfg,
  output int   mismatches,
  output int   in_flight
);

  // Wide enough for any full product of two 40-bit values plus a carry
  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             in_set;
  } escape_t;

  // Local copy of the view and the limit
  logic signed [ORG_W-1:0]  x_org;
  logic signed [STEP_W-1:0] x_inc;
  logic signed [ORG_W-1:0]  y_org;
  logic signed [STEP_W-1:0] y_inc;
  logic [CNT_W-1:0]         limit;

  escape_t expected_q[$];
  int      fail_cnt = 0;
  int      queued   = 0;

  assign mismatches = fail_cnt;
  assign in_flight  = queued;

  // Saturate to a w-bit signed range
  function automatic wide_t clip(input wide_t v, input int w);
    wide_t top_val;
    wide_t bot_val;
    top_val = (wide_t'(1) <<< (w - 1)) - wide_t'(1);
    bot_val = -top_val - wide_t'(1);
    if (v > top_val) return top_val;
    if (v < bot_val) return bot_val;
    return v;
  endfunction

  // Map the pixel to c and iterate z = z*z + c from z = c
  function automatic escape_t escape_time(input logic [COORD_W-1:0] col,
                                          input logic [COORD_W-1:0] row);
    wide_t       cr;
    wide_t       ci;
    wide_t       zr;
    wide_t       zi;
    wide_t       sq_diff;
    wide_t       cross_sh;
    wide_t       mag2;
    logic [COORD_W-1:0] cc;
    logic [COORD_W-1:0] rr;
    int unsigned n;
    escape_t     r;
    // clamp indexes beyond the image
    cc = (int'(col) > MAX_COLUMNS - 1) ? COORD_W'(MAX_COLUMNS - 1) : col;
    rr = (int'(row) > MAX_ROWS - 1) ? COORD_W'(MAX_ROWS - 1) : row;
    cr = clip(wide_t'(x_org) + wide_t'($signed({1'b0, cc})) * wide_t'(x_inc), C_W);
    ci = clip(wide_t'(y_org) + wide_t'($signed({1'b0, rr})) * wide_t'(y_inc), C_W);
    zr = cr;
    zi = ci;
    n  = 0;
    while (n < limit) begin
      // floor shift of exact products, then saturate before and after adding c
      sq_diff  = (zr * zr - zi * zi) >>> FRAC_BITS;
      cross_sh = ((zr * zi) <<< 1) >>> FRAC_BITS;
      zr = clip(clip(sq_diff, Z_W) + cr, Z_W);
      zi = clip(clip(cross_sh, Z_W) + ci, Z_W);
      mag2 = zr * zr + zi * zi;
      // |z|^2 > 4, exactly 4 does not escape
      if (mag2 > (wide_t'(1) <<< ESC_SHIFT)) break;
      n++;
    end
    r.count  = CNT_W'(n);
    r.in_set = (n == limit);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    escape_t want;
    int      errs;
    errs = 0;
    if (!rst_n) begin
      x_org = X_ORIGIN_RST;
      x_inc = X_STEP_RST;
      y_org = Y_ORIGIN_RST;
      y_inc = Y_STEP_RST;
      limit = LIMIT_RST;
      expected_q.delete();
    end else begin
      // result first: a word leaving now belongs to an earlier pixel
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with no pixel waiting: iteration_count %0d inside_set %0b",
                 res.iteration_count, res.inside_set);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (res.iteration_count !== want.count) begin
            $error("iteration_count: expected %0d, got %0d", want.count,
                   res.iteration_count);
            errs++;
          end
          if (res.inside_set !== want.in_set) begin
            $error("inside_set: expected %0b, got %0b", want.in_set, res.inside_set);
            errs++;
          end
        end
      end
      // register writes; unmapped indexes change nothing
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_X_ORIGIN:   x_org = cfg.data[ORG_W-1:0];
          CFG_X_STEP:     x_inc = cfg.data[STEP_W-1:0];
          CFG_Y_ORIGIN:   y_org = cfg.data[ORG_W-1:0];
          CFG_Y_STEP:     y_inc = cfg.data[STEP_W-1:0];
          CFG_ITER_LIMIT: limit = cfg.data[CNT_W-1:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        expected_q.push_back(escape_time(pix.column, pix.row));
      end
    end
    fail_cnt <= fail_cnt + errs;
    queued   <= expected_q.size();
  end

endmodule

// File: tb/sv/tb_mandelbrot_escape_time.sv
`timescale 1ns / 1ps

module tb_mandelbrot_escape_time;
  import mnd_pkg::*;

  localparam longint Q_ONE = longint'(1) << FRAC_BITS;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  logic clk;
  logic rst_n;
  bit   steady = 1'b0;
  int   miscompares;
  int   awaiting;

  mnd_pix_if pix ();
  mnd_res_if res ();
  mnd_cfg_if cfg ();

  mandelbrot_escape_time dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix),
    .out_res (res),
    .cfg_wr  (cfg)
  );

  mandelbrot_escape_checker escape_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .pix        (pix),
    .res        (res),
    .cfg        (cfg),
    .mismatches (miscompares),
    .in_flight  (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int idle_cycles();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side back-pressure
  initial begin : result_stall
    int hold;
    hold = 0;
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        hold--;
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
        hold = idle_cycles();
      end
    end
  end

  // One pixel word, held until taken
  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid  <= 1'b1;
    pix.column <= col;
    pix.row    <= row;
    do @(posedge clk); while (!pix.ready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  // Stop feeding and wait for every pixel to come back
  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin : stimulus
    int     phase;
    int     k;
    int     lim;
    longint span;
    longint center_re;
    longint center_im;
    longint step_re;
    longint step_im;
    longint org_re;
    longint org_im;

    rst_n      <= 1'b0;
    pix.valid  <= 1'b0;
    pix.column <= '0;
    pix.row    <= '0;
    cfg.valid  <= 1'b0;
    cfg.index  <= '0;
    cfg.data   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default view: corners, bit patterns and two points that never leave
    send_pixel(12'd0, 12'd0);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    send_pixel(12'd0, 12'hFFF);
    send_pixel(12'd683, 12'd512);   // c just right of zero
    send_pixel(12'd0, 12'd512);     // c = -2: |z|^2 stays at exactly 4
    send_pixel(12'hAAA, 12'h555);
    send_pixel(12'h555, 12'hAAA);
    settle();

    // zero limit: no iteration, reported as inside
    write_reg(CFG_ITER_LIMIT, 0);
    send_pixel(12'd683, 12'd512);
    send_pixel(12'd0, 12'd0);
    settle();

    write_reg(CFG_ITER_LIMIT, 1);
    send_pixel(12'd683, 12'd512);
    send_pixel(12'd0, 12'd512);
    send_pixel(12'd0, 12'd0);
    settle();

    // largest view: c saturates, z saturates on the first squaring
    write_reg(CFG_X_ORIGIN, (longint'(1) << 27) - 1);
    write_reg(CFG_X_STEP, (longint'(1) << 25) - 1);
    write_reg(CFG_Y_ORIGIN, (longint'(1) << 27) - 1);
    write_reg(CFG_Y_STEP, (longint'(1) << 25) - 1);
    write_reg(CFG_ITER_LIMIT, 4095);
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'd0, 12'd0);
    settle();

    // most negative view
    write_reg(CFG_X_ORIGIN, -(longint'(1) << 27));
    write_reg(CFG_X_STEP, -(longint'(1) << 25));
    write_reg(CFG_Y_ORIGIN, -(longint'(1) << 27));
    write_reg(CFG_Y_STEP, -(longint'(1) << 25));
    send_pixel(12'hFFF, 12'hFFF);
    send_pixel(12'hFFF, 12'd0);
    settle();

    // c = 0 everywhere: full run to the top limit
    write_reg(CFG_X_ORIGIN, 0);
    write_reg(CFG_X_STEP, 0);
    write_reg(CFG_Y_ORIGIN, 0);
    write_reg(CFG_Y_STEP, 0);
    send_pixel(12'h123, 12'hFED);
    settle();

    // writes to unmapped indexes leave the view alone
    write_reg(CFG_ITER_LIMIT, 3);
    write_reg(CFG_UNUSED_LO, longint'($urandom()));
    write_reg(CFG_UNUSED_HI, longint'($urandom()));
    send_pixel(12'hFED, 12'h123);
    settle();

    // random views, most of them framing the set
    for (phase = 0; phase < 8; phase++) begin
      steady <= (phase % 4 == 3);
      lim = ($urandom_range(0, 3) == 0) ? $urandom_range(65, 300) : $urandom_range(1, 64);
      if ($urandom_range(0, 3) == 0) begin
        // raw bits, upper data bits of the steps included
        org_re  = longint'($urandom());
        step_re = longint'($urandom());
        org_im  = longint'($urandom());
        step_im = longint'($urandom());
      end else begin
        span      = longint'($urandom_range(Q_ONE / 16, 3 * Q_ONE));
        center_re = longint'($urandom_range(0, 21 * Q_ONE / 10)) - 18 * Q_ONE / 10;
        center_im = longint'($urandom_range(0, 2 * Q_ONE)) - Q_ONE;
        step_re   = span / 4096;
        step_im   = span / 4096;
        org_re    = center_re - span / 2;
        org_im    = center_im - span / 2;
        if ($urandom_range(0, 1) == 1) begin
          step_re = -step_re;
          org_re  = center_re + span / 2;
        end
        if ($urandom_range(0, 1) == 1) begin
          step_im = -step_im;
          org_im  = center_im + span / 2;
        end
      end
      write_reg(CFG_X_ORIGIN, org_re);
      write_reg(CFG_X_STEP, step_re);
      write_reg(CFG_Y_ORIGIN, org_im);
      write_reg(CFG_Y_STEP, step_im);
      write_reg(CFG_ITER_LIMIT, lim);
      for (k = 0; k < 75; k++) begin
        send_pixel(COORD_W'($urandom()), COORD_W'($urandom()));
      end
      settle();
    end

    if (miscompares == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: mandelbrot_escape_time.f
design/mnd_pkg.sv
design/mnd_pix_if.sv
design/mnd_res_if.sv
design/mnd_cfg_if.sv
design/mnd_fifo.sv
design/mnd_front.sv
design/mnd_iter.sv
design/mandelbrot_escape_time.sv
tb/sv/mandelbrot_escape_checker.sv
tb/sv/tb_mandelbrot_escape_time.sv
